// ===== sv/bgcd_pkg.sv =====
// Shared constants and types for the binary GCD block.
// Used by bgcd_ctrl, bgcd_datapath and binary_gcd_64; depends on nothing.
`default_nettype none

package bgcd_pkg;

   localparam int unsigned GCD_PORT_W  = 64;
   localparam int unsigned GCD_WIDTH_D = 64;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_BUSY = 2'b10
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic finished;
   } status_type;

endpackage

`default_nettype wire

// ===== sv/bgcd_ctrl.sv =====
// Controller state machine for the binary GCD block: handshakes and sequencing.
// Depends on bgcd_pkg; drives bgcd_datapath through cmd_type and reads status_type.
`default_nettype none

module bgcd_ctrl import bgcd_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (status.finished) begin
               if (out_free) begin
                  cmd.emit = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.emit | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/bgcd_datapath.sv =====
// Datapath for the binary GCD block: operand registers, shared-power counter,
// one halve or subtract-and-halve step per cycle, and the result register.
// Depends on bgcd_pkg; commanded by bgcd_ctrl.
`default_nettype none

module bgcd_datapath import bgcd_pkg::*; #(
   parameter int unsigned WIDTH = GCD_WIDTH_D
) (
   input  wire                     clock,
   input  wire  [GCD_PORT_W-1:0]   req_operand_a,
   input  wire  [GCD_PORT_W-1:0]   req_operand_b,
   input  cmd_type                 cmd,
   output status_type              status,
   output logic [GCD_PORT_W-1:0]   rsp_divisor
);

   localparam int unsigned CW = $clog2(WIDTH);

   logic [WIDTH-1:0]  x_ff, x_in, y_ff, y_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              zero_ff, zero_in;
   logic [WIDTH-1:0]  res_ff, res_in;
   logic [WIDTH:0]    diff_yx;
   logic [WIDTH-1:0]  diff_xy;
   logic              borrow;
   logic [WIDTH-1:0]  gcd_value;

   assign diff_yx = {1'b0, y_ff} - {1'b0, x_ff};
   assign diff_xy = x_ff - y_ff;
   assign borrow  = diff_yx[WIDTH];

   assign status.finished = zero_ff || (x_ff[0] && y_ff[0] && (x_ff == y_ff));
   assign gcd_value       = zero_ff ? (x_ff | y_ff) : (x_ff << cnt_ff);

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      cnt_in  = cnt_ff;
      zero_in = zero_ff;
      res_in  = res_ff;
      if (cmd.load) begin
         x_in    = req_operand_a[WIDTH-1:0];
         y_in    = req_operand_b[WIDTH-1:0];
         cnt_in  = '0;
         zero_in = (req_operand_a[WIDTH-1:0] == '0) || (req_operand_b[WIDTH-1:0] == '0);
      end else if (cmd.step) begin
         priority if (!x_ff[0] && !y_ff[0]) begin
            x_in   = x_ff >> 1;
            y_in   = y_ff >> 1;
            cnt_in = cnt_ff + CW'(1);
         end else if (!x_ff[0]) begin
            x_in = x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_in = y_ff >> 1;
         end else if (borrow) begin
            x_in = y_ff;
            y_in = diff_xy >> 1;
         end else begin
            y_in = diff_yx[WIDTH-1:0] >> 1;
         end
      end
      if (cmd.emit) begin
         res_in = gcd_value;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      cnt_ff  <= cnt_in;
      zero_ff <= zero_in;
      res_ff  <= res_in;
   end

   assign rsp_divisor = GCD_PORT_W'(res_ff);

endmodule

`default_nettype wire

// ===== sv/binary_gcd_64.sv =====
// Binary GCD block: one operand pair in, its greatest common divisor out.
// From accept to result valid the datapath takes one step per cycle, each step
// removing at least one operand bit, then emits once the output register is free.
// One pair is in work at a time and the input is stalled until its result is emitted;
// a finished word may wait in the output register while the output is stalled.
// Synchronous active-high reset clears the controller and the output valid.
`default_nettype none

module binary_gcd_64 import bgcd_pkg::*; #(
   parameter int unsigned WIDTH = GCD_WIDTH_D
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire  [GCD_PORT_W-1:0]  req_operand_a,
   input  wire  [GCD_PORT_W-1:0]  req_operand_b,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output logic [GCD_PORT_W-1:0]  rsp_divisor
);

   cmd_type    cmd;
   status_type status;

   bgcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bgcd_datapath #(
      .WIDTH (WIDTH)
   ) u_datapath (
      .clock         (clock),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .cmd           (cmd),
      .status        (status),
      .rsp_divisor   (rsp_divisor)
   );

endmodule

`default_nettype wire
